>>> rtl/cllq_pkg.sv
// Shared types and constants of the circular linked-list queue.
package cllq_pkg;

    // Fixed widths of the request and result fields
    localparam int TYPE_W = 2;
    localparam int NODE_W = 6;

    // Request codes
    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT      = 2'd0,
        REQ_REMOVE_HEAD = 2'd1,
        REQ_REMOVE_NODE = 2'd2
    } req_type_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS2,
        S_RH,
        S_RH2,
        S_WALK,
        S_UNLINK,
        S_HOLD
    } state_t;

    // One result beat
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] node;
    } result_t;

endpackage

>>> rtl/cllq_req_if.sv
// Request channel: valid/ready handshake with request type and node number.
interface cllq_req_if;
    logic                         valid;
    logic                         ready;
    logic [cllq_pkg::TYPE_W-1:0]  req_type;
    logic [cllq_pkg::NODE_W-1:0]  node_id;

    modport source (output valid, output req_type, output node_id, input ready);
    modport sink   (input valid, input req_type, input node_id, output ready);
endinterface

>>> rtl/cllq_rsp_if.sv
// Result channel: valid/ready handshake with removal flag and node number.
interface cllq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         removed_valid;
    logic [cllq_pkg::NODE_W-1:0]  removed_node;

    modport source (output valid, output removed_valid, output removed_node, input ready);
    modport sink   (input valid, input removed_valid, input removed_node, output ready);
endinterface

>>> rtl/cllq_link_ram.sv
// Next-link memory: one write port, one read port, registered read data.
module cllq_link_ram #(
    parameter int NODES = 64
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(NODES)-1:0]   waddr,
    input  logic [$clog2(NODES)-1:0]   wdata,
    input  logic                       re,
    input  logic [$clog2(NODES)-1:0]   raddr,
    output logic [$clog2(NODES)-1:0]   rdata
);

    localparam int NW = $clog2(NODES);

    logic [NW-1:0] mem [NODES];
    logic [NW-1:0] rdata_reg;

    // Write the link entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read the link entry; hold the last read data otherwise
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cllq_ctrl.sv
// Sequencer: runs each request as reads and write-backs of the link memory.
module cllq_ctrl #(
    parameter int NODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cllq_pkg::TYPE_W-1:0]   in_type,
    input  logic [cllq_pkg::NODE_W-1:0]   in_node,
    output logic                          res_valid,
    input  logic                          res_ready,
    output cllq_pkg::result_t             res,
    output logic                          mem_we,
    output logic [$clog2(NODES)-1:0]      mem_waddr,
    output logic [$clog2(NODES)-1:0]      mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(NODES)-1:0]      mem_raddr,
    input  logic [$clog2(NODES)-1:0]      mem_rdata
);

    localparam int NW = $clog2(NODES);
    localparam int SW = $clog2(NODES);

    cllq_pkg::state_t  state_reg, state_next;
    logic              nonempty_reg, nonempty_next;
    logic [NW-1:0]     tail_reg, tail_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [NW-1:0]     prev_reg, prev_next;
    logic [NW-1:0]     curr_reg, curr_next;
    logic [SW-1:0]     steps_reg, steps_next;
    cllq_pkg::result_t res_reg, res_next;

    logic              accept;
    logic              node_ok;
    logic [NW-1:0]     in_idx;
    logic              hit;
    logic              at_tail;
    logic              last_step;
    logic              head_is_tail;
    logic              fin;
    cllq_pkg::result_t fin_res;
    cllq_pkg::req_type_t req;

    // Decode the request and walk conditions
    always_comb
    begin
        accept       = in_valid && (state_reg == cllq_pkg::S_IDLE);
        node_ok      = 32'(in_node) < 32'(NODES);
        in_idx       = NW'(in_node);
        req          = cllq_pkg::req_type_t'(in_type);
        hit          = mem_rdata == node_reg;
        at_tail      = mem_rdata == tail_reg;
        last_step    = steps_reg == SW'(NODES - 1);
        head_is_tail = mem_rdata == tail_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cllq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        cllq_pkg::REQ_INSERT:
                        begin
                            if (node_ok && nonempty_reg)
                                state_next = cllq_pkg::S_INS;
                            else if (!res_ready)
                                state_next = cllq_pkg::S_HOLD;
                        end
                        cllq_pkg::REQ_REMOVE_HEAD:
                        begin
                            if (nonempty_reg)
                                state_next = cllq_pkg::S_RH;
                            else if (!res_ready)
                                state_next = cllq_pkg::S_HOLD;
                        end
                        cllq_pkg::REQ_REMOVE_NODE:
                        begin
                            if (nonempty_reg && node_ok)
                                state_next = cllq_pkg::S_WALK;
                            else if (!res_ready)
                                state_next = cllq_pkg::S_HOLD;
                        end
                        default:
                        begin
                            if (!res_ready)
                                state_next = cllq_pkg::S_HOLD;
                        end
                    endcase
                end
            end
            cllq_pkg::S_INS:
                state_next = cllq_pkg::S_INS2;
            cllq_pkg::S_INS2:
                state_next = res_ready ? cllq_pkg::S_IDLE : cllq_pkg::S_HOLD;
            cllq_pkg::S_RH:
            begin
                if (!head_is_tail)
                    state_next = cllq_pkg::S_RH2;
                else
                    state_next = res_ready ? cllq_pkg::S_IDLE : cllq_pkg::S_HOLD;
            end
            cllq_pkg::S_RH2:
                state_next = res_ready ? cllq_pkg::S_IDLE : cllq_pkg::S_HOLD;
            cllq_pkg::S_WALK:
            begin
                if (hit)
                    state_next = cllq_pkg::S_UNLINK;
                else if (at_tail || last_step)
                    state_next = res_ready ? cllq_pkg::S_IDLE : cllq_pkg::S_HOLD;
            end
            cllq_pkg::S_UNLINK:
                state_next = res_ready ? cllq_pkg::S_IDLE : cllq_pkg::S_HOLD;
            cllq_pkg::S_HOLD:
            begin
                if (res_ready)
                    state_next = cllq_pkg::S_IDLE;
            end
            default:
                state_next = cllq_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, list updates and result
    always_comb
    begin
        nonempty_next = nonempty_reg;
        tail_next     = tail_reg;
        node_next     = node_reg;
        prev_next     = prev_reg;
        curr_next     = curr_reg;
        steps_next    = steps_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_reg;
        mem_wdata     = node_reg;
        mem_re        = 1'b0;
        mem_raddr     = tail_reg;
        fin           = 1'b0;
        fin_res       = '0;
        in_ready      = state_reg == cllq_pkg::S_IDLE;

        unique case (state_reg)
            cllq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    node_next  = in_idx;
                    prev_next  = tail_reg;
                    steps_next = '0;
                    unique case (req)
                        cllq_pkg::REQ_INSERT:
                        begin
                            if (!node_ok)
                            begin
                                fin = 1'b1;
                            end
                            else if (!nonempty_reg)
                            begin
                                // First node links to itself
                                mem_we        = 1'b1;
                                mem_waddr     = in_idx;
                                mem_wdata     = in_idx;
                                tail_next     = in_idx;
                                nonempty_next = 1'b1;
                                fin           = 1'b1;
                            end
                            else
                            begin
                                mem_re = 1'b1;
                            end
                        end
                        cllq_pkg::REQ_REMOVE_HEAD:
                        begin
                            if (nonempty_reg)
                                mem_re = 1'b1;
                            else
                                fin = 1'b1;
                        end
                        cllq_pkg::REQ_REMOVE_NODE:
                        begin
                            if (nonempty_reg && node_ok)
                                mem_re = 1'b1;
                            else
                                fin = 1'b1;
                        end
                        default:
                            fin = 1'b1;
                    endcase
                end
            end
            cllq_pkg::S_INS:
            begin
                // New node takes over the old head link
                mem_we    = 1'b1;
                mem_waddr = node_reg;
                mem_wdata = mem_rdata;
            end
            cllq_pkg::S_INS2:
            begin
                // Old tail points at the new node, which becomes the tail
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                mem_wdata = node_reg;
                tail_next = node_reg;
                fin       = 1'b1;
            end
            cllq_pkg::S_RH:
            begin
                curr_next = mem_rdata;
                if (head_is_tail)
                begin
                    nonempty_next = 1'b0;
                    fin           = 1'b1;
                    fin_res.found = 1'b1;
                    fin_res.node  = cllq_pkg::NODE_W'(mem_rdata);
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata;
                end
            end
            cllq_pkg::S_RH2:
            begin
                // Tail skips the removed head
                mem_we        = 1'b1;
                mem_waddr     = tail_reg;
                mem_wdata     = mem_rdata;
                fin           = 1'b1;
                fin_res.found = 1'b1;
                fin_res.node  = cllq_pkg::NODE_W'(curr_reg);
            end
            cllq_pkg::S_WALK:
            begin
                if (hit)
                begin
                    curr_next = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata;
                end
                else if (at_tail || last_step)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    // Advance one link
                    prev_next  = mem_rdata;
                    steps_next = steps_reg + SW'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = mem_rdata;
                end
            end
            cllq_pkg::S_UNLINK:
            begin
                // Predecessor skips the found node; pull the tail back if needed
                mem_we    = 1'b1;
                mem_waddr = prev_reg;
                mem_wdata = mem_rdata;
                if (curr_reg == tail_reg)
                begin
                    if (prev_reg == tail_reg)
                        nonempty_next = 1'b0;
                    else
                        tail_next = prev_reg;
                end
                fin           = 1'b1;
                fin_res.found = 1'b1;
                fin_res.node  = cllq_pkg::NODE_W'(curr_reg);
            end
            cllq_pkg::S_HOLD:
            begin
            end
            default:
            begin
            end
        endcase

        res_valid = fin || (state_reg == cllq_pkg::S_HOLD);
        res       = (state_reg == cllq_pkg::S_HOLD) ? res_reg : fin_res;
        res_next  = fin ? fin_res : res_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cllq_pkg::S_IDLE;
            nonempty_reg <= 1'b0;
            tail_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            tail_reg     <= tail_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        prev_reg  <= prev_next;
        curr_reg  <= curr_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

endmodule

>>> rtl/circular_linked_list_queue.sv
// Circular linked-list queue: sequencer over a next-link memory, registered result.
// Throughput: one request at a time, taken the cycle after the last one finishes in the
//   sequencer; a waiting result blocks the next request.
// Reset: list empty, tail 0; the link memory is not cleared and needs no sweep.
module circular_linked_list_queue #(
    parameter int NODES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    cllq_req_if.sink   req,
    cllq_rsp_if.source rsp
);

    localparam int NW = $clog2(NODES);

    logic              res_valid;
    logic              res_ready;
    cllq_pkg::result_t res;
    logic              mem_we;
    logic [NW-1:0]     mem_waddr;
    logic [NW-1:0]     mem_wdata;
    logic              mem_re;
    logic [NW-1:0]     mem_raddr;
    logic [NW-1:0]     mem_rdata;

    logic              out_valid_reg, out_valid_next;
    cllq_pkg::result_t out_res_reg, out_res_next;

    cllq_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_type   (req.req_type),
        .in_node   (req.node_id),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    cllq_link_ram #(
        .NODES (NODES)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load a result beat when the register is free or being drained
    always_comb
    begin
        res_ready      = !out_valid_reg || rsp.ready;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_valid = out_res_reg.found;
    assign rsp.removed_node  = out_res_reg.node;

endmodule

>>> test/circular_linked_list_queue_tb.sv
// Testbench for the circular linked-list queue, checked against a link-memory predictor.
`timescale 1ns / 1ps

module circular_linked_list_queue_tb;

    localparam int TYPE_W = cllq_pkg::TYPE_W;
    localparam int NODE_W = cllq_pkg::NODE_W;
    localparam int POOL = 64;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 150;
    localparam int CALM_ITEMS = 80;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD = 80;
    localparam int HOLD_AT = 300;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [NODE_W-1:0] id;
        logic              drain;
    } request_t;

    logic clk;
    logic rst_n = 1'b0;

    cllq_req_if req_bus ();
    cllq_rsp_if rsp_bus ();

    circular_linked_list_queue #(.NODES(POOL)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Requests waiting to be driven, and removals still owed by the block
    request_t          pending_reqs[$];
    cllq_pkg::result_t removal_q[$];
    cllq_pkg::result_t due_result;

    // List order, head first, as the stimulus planner sees it
    logic [NODE_W-1:0] plan_order[$];
    int plan_peak;

    // Predictor state: valid bit, tail pointer and next-link memory
    logic              list_live;
    logic [NODE_W-1:0] list_tail;
    logic [NODE_W-1:0] link_mem [POOL];

    int item_total;
    int accepted_reqs;
    int results_seen;
    int mismatch_count;
    int nodes_returned;
    int empty_answers;
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    logic calm;
    assign calm = (accepted_reqs + CALM_ITEMS >= item_total);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the predictor and return the removal it causes
    function automatic cllq_pkg::result_t predict_removal(input logic [TYPE_W-1:0] kind,
                                                          input logic [NODE_W-1:0] id);
        cllq_pkg::result_t r;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] prev;
        logic [NODE_W-1:0] curr;
        bit                done;
        r = '0;
        done = 1'b0;
        case (kind)
            cllq_pkg::REQ_INSERT:
            begin
                if (list_live)
                begin
                    link_mem[id] = link_mem[list_tail];
                    link_mem[list_tail] = id;
                end
                else
                begin
                    link_mem[id] = id;
                end
                list_tail = id;
                list_live = 1'b1;
            end
            cllq_pkg::REQ_REMOVE_HEAD:
            begin
                if (list_live)
                begin
                    head = link_mem[list_tail];
                    if (head == list_tail)
                        list_live = 1'b0;
                    else
                        link_mem[list_tail] = link_mem[head];
                    r.found = 1'b1;
                    r.node = head;
                end
            end
            cllq_pkg::REQ_REMOVE_NODE:
            begin
                if (list_live)
                begin
                    curr = list_tail;
                    // Walk from the head, at most one lap of the pool
                    for (int s = 0; s < POOL && !done; s++)
                    begin
                        prev = curr;
                        curr = link_mem[prev];
                        if (curr == id)
                        begin
                            link_mem[prev] = link_mem[curr];
                            if (curr == list_tail)
                            begin
                                if (prev == list_tail)
                                    list_live = 1'b0;
                                else
                                    list_tail = prev;
                            end
                            r.found = 1'b1;
                            r.node = curr;
                            done = 1'b1;
                        end
                        else if (curr == list_tail)
                        begin
                            done = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int plan_find(input logic [NODE_W-1:0] id);
        foreach (plan_order[i])
            if (plan_order[i] == id)
                return i;
        return -1;
    endfunction

    function automatic logic [NODE_W-1:0] pick_unlisted();
        logic [NODE_W-1:0] cand;
        do
            cand = NODE_W'($urandom_range(0, POOL - 1));
        while (plan_find(cand) >= 0);
        return cand;
    endfunction

    function automatic logic [NODE_W-1:0] pick_listed();
        return plan_order[$urandom_range(0, plan_order.size() - 1)];
    endfunction

    // Queue a request and track the list order it leaves behind
    function automatic void plan_request(input logic [TYPE_W-1:0] kind,
                                         input logic [NODE_W-1:0] id,
                                         input logic drain);
        int at;
        at = plan_find(id);
        pending_reqs.push_back({kind, id, drain});
        case (kind)
            cllq_pkg::REQ_INSERT:
            begin
                if (at < 0)
                begin
                    plan_order.push_back(id);
                end
                else if (at == 0 || at == plan_order.size() - 1)
                begin
                    // Re-inserting the head or the tail leaves a single node
                    plan_order.delete();
                    plan_order.push_back(id);
                end
                else
                begin
                    // Re-inserting a middle node drops everything after it
                    plan_order = plan_order[0:at];
                end
            end
            cllq_pkg::REQ_REMOVE_HEAD:
                if (plan_order.size() > 0)
                    void'(plan_order.pop_front());
            cllq_pkg::REQ_REMOVE_NODE:
                if (at >= 0)
                    plan_order.delete(at);
            default: ;
        endcase
        if (plan_order.size() > plan_peak)
            plan_peak = plan_order.size();
    endfunction

    // Driver: present pending requests, predict each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.req_type <= cllq_pkg::REQ_INSERT;
            req_bus.node_id <= '0;
            gap_left <= 0;
            list_live = 1'b0;
            list_tail = '0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                removal_q.push_back(predict_removal(req_bus.req_type, req_bus.node_id));
                accepted_reqs++;
            end
            if (req_bus.valid && !req_bus.ready)
            begin
                // hold the beat until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_bus.valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain && removal_q.size() != 0))
            begin
                req_bus.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap_left <= $urandom_range(0, 2);
                req_bus.valid <= 1'b0;
            end
            else
            begin
                req_bus.valid <= 1'b1;
                req_bus.req_type <= pending_reqs[0].kind;
                req_bus.node_id <= pending_reqs[0].id;
                void'(pending_reqs.pop_front());
            end
        end
    end

    // Monitor: check each result beat, pace ready with stalls and one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                results_seen++;
                if (removal_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, %s %0d %s %0d",
                             $time, "actual removed_valid", rsp_bus.removed_valid,
                             "removed_node", rsp_bus.removed_node);
                end
                else
                begin
                    due_result = removal_q.pop_front();
                    if (rsp_bus.removed_valid !== due_result.found)
                    begin
                        mismatch_count++;
                        $display("%0t: removed_valid mismatch, expected %0d, actual %0d",
                                 $time, due_result.found, rsp_bus.removed_valid);
                    end
                    if (rsp_bus.removed_node !== due_result.node)
                    begin
                        mismatch_count++;
                        $display("%0t: removed_node mismatch, expected %0d, actual %0d",
                                 $time, due_result.node, rsp_bus.removed_node);
                    end
                    if (due_result.found)
                        nodes_returned++;
                    else
                        empty_answers++;
                end
            end
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int targets[5];
        int pick;
        int fill;
        logic drain;
        targets = '{3, 16, POOL, 8, 40};

        // Empty list, unused code, single-node lists, extreme node numbers
        plan_request(cllq_pkg::REQ_REMOVE_HEAD, 6'd63, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd0, 1'b0);
        plan_request(REQ_UNUSED, 6'd63, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd0, 1'b1);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd0, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd63, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_HEAD, 6'd0, 1'b0);
        // Tail removal moves the tail back; missing node; head by number
        plan_request(cllq_pkg::REQ_INSERT, 6'd0, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd63, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd21, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd42, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd42, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd5, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd0, 1'b0);
        plan_request(REQ_UNUSED, 6'd0, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_HEAD, 6'd0, 1'b0);
        // Re-insert of listed nodes: tail, head, then a middle node
        plan_request(cllq_pkg::REQ_INSERT, 6'd21, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd7, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd21, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd11, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd12, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd13, 1'b0);
        plan_request(cllq_pkg::REQ_INSERT, 6'd12, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_NODE, 6'd21, 1'b0);
        plan_request(cllq_pkg::REQ_REMOVE_HEAD, 6'd0, 1'b0);

        // Random phases, each steering the list toward its own size
        foreach (targets[p])
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                drain = (n == 0);
                pick = $urandom_range(0, 99);
                fill = plan_order.size();
                if (pick < 3)
                    plan_request(REQ_UNUSED, NODE_W'($urandom_range(0, POOL - 1)), drain);
                else if (pick < 6 && fill > 0)
                    plan_request(cllq_pkg::REQ_INSERT, pick_listed(), drain);
                else if (pick < 10 && fill < POOL)
                    plan_request(cllq_pkg::REQ_REMOVE_NODE, pick_unlisted(), drain);
                else if (fill == 0 || (fill < targets[p] && $urandom_range(0, 3) != 0))
                    plan_request(cllq_pkg::REQ_INSERT, pick_unlisted(), drain);
                else if ($urandom_range(0, 1) == 0)
                    plan_request(cllq_pkg::REQ_REMOVE_HEAD,
                                 NODE_W'($urandom_range(0, POOL - 1)), drain);
                else
                    plan_request(cllq_pkg::REQ_REMOVE_NODE, pick_listed(), drain);
            end
        end
        item_total = pending_reqs.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (!(accepted_reqs == item_total && removal_q.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d nodes returned, %0d answers with no removal.",
                 accepted_reqs, nodes_returned, empty_answers);
        $display("The list reached %0d nodes; %s", plan_peak,
                 "re-inserts, unused codes and a long result hold-off included.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/cllq_pkg.sv
rtl/cllq_req_if.sv
rtl/cllq_rsp_if.sv
rtl/cllq_link_ram.sv
rtl/cllq_ctrl.sv
rtl/circular_linked_list_queue.sv
test/circular_linked_list_queue_tb.sv
